// ===== hw/rtl/bal_pkg.sv =====
// Package for the cubic Bezier arc-length table block.
// Holds the curve, work and table entry types and fixed constants.
// No dependencies.
package bal_pkg;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] ctrl1_x;
        logic signed [31:0] ctrl1_y;
        logic signed [31:0] ctrl2_x;
        logic signed [31:0] ctrl2_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
    } bal_curve_t;

    typedef struct packed {
        logic [5:0]  entry_index;
        logic [16:0] norm_length;
        logic [16:0] param_t;
        logic [47:0] total_length;
        logic        last_entry;
    } bal_entry_t;

    // One curve waiting for the engine, with its front-end classification.
    typedef struct packed {
        bal_curve_t curve;
        logic       flat;
    } bal_task_t;

    localparam logic [47:0] LEN_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [5:0]  ROOT_LAST  = 6'd32;
    localparam logic [5:0]  QUO_LAST   = 6'd16;

endpackage

// ===== hw/rtl/bal_fifo.sv =====
// Small first-in first-out queue built from registers.
// Generic in width and depth; no package dependency.
module bal_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push_ok && !pop_ok)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_ok && !push_ok)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/bal_front.sv =====
// Front end: takes curves in, holds one, and marks curves whose four
// control points coincide. Depends on bal_pkg.
module bal_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  bal_pkg::bal_curve_t item,
    output logic                task_push,
    output bal_pkg::bal_task_t  task_data,
    input  logic                task_full
);
    import bal_pkg::*;

    logic       hold_valid_reg;
    bal_curve_t hold_reg;
    logic       take;

    assign full      = hold_valid_reg && task_full;
    assign take      = push && !full;
    assign task_push = hold_valid_reg && !task_full;

    // A curve whose control points are all equal has zero length everywhere.
    assign task_data.curve = hold_reg;
    assign task_data.flat  = (hold_reg.ctrl1_x == hold_reg.start_x)
                          && (hold_reg.ctrl2_x == hold_reg.start_x)
                          && (hold_reg.end_x   == hold_reg.start_x)
                          && (hold_reg.ctrl1_y == hold_reg.start_y)
                          && (hold_reg.ctrl2_y == hold_reg.start_y)
                          && (hold_reg.end_y   == hold_reg.start_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (task_push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg <= item;
        end
    end

endmodule

// ===== hw/rtl/bal_engine.sv =====
// Back end: samples one curve on a shared multiplier, takes chord lengths
// with a bit-serial square root, then normalizes each interior entry with a
// serial divider. Depends on bal_pkg.
module bal_engine #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                task_empty,
    input  bal_pkg::bal_task_t  task_data,
    output logic                task_pop,
    input  logic                out_full,
    output logic                out_push,
    output bal_pkg::bal_entry_t out_data
);
    import bal_pkg::*;

    localparam int AW     = $clog2(TABLE_ENTRIES);
    localparam int DIVN   = TABLE_ENTRIES - 1;
    localparam int STEP_Q = 65536 / DIVN;
    localparam int STEP_R = 65536 % DIVN;
    localparam int RW     = $clog2(2 * DIVN);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ROOT, S_ACCUM, S_READ, S_LOAD, S_DIVIDE, S_EMIT
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        idx_reg;
    logic [4:0]           mop_reg;
    logic [5:0]           step_reg;
    logic [16:0]          tq_reg;
    logic [RW-1:0]        tr_reg;

    bal_curve_t           curve_reg;
    logic signed [69:0]   prod_reg;
    logic [32:0]          u2_reg;
    logic [32:0]          t2_reg;
    logic [48:0]          w_reg [4];
    logic signed [81:0]   acc_reg;
    logic signed [32:0]   dx_reg;
    logic signed [32:0]   dy_reg;
    logic signed [31:0]   cx_reg;
    logic signed [31:0]   cy_reg;
    logic signed [31:0]   prevx_reg;
    logic signed [31:0]   prevy_reg;
    logic [64:0]          sq_reg;
    logic [65:0]          rad_reg;
    logic [35:0]          rem_reg;
    logic [32:0]          root_reg;
    logic [47:0]          run_reg;
    logic [48:0]          drem_reg;
    logic [16:0]          quo_reg;
    logic [47:0]          mem [TABLE_ENTRIES];
    logic [47:0]          rdata_reg;

    logic [16:0]          u_val;
    logic [4:0]           jop;
    logic [4:0]           cop;
    logic signed [31:0]   coord_val;
    logic [48:0]          w_sel;
    logic signed [34:0]   a_op;
    logic signed [34:0]   b_op;
    logic signed [69:0]   prod_next;
    logic signed [81:0]   term;
    logic signed [31:0]   acc_coord;
    logic [48:0]          m3;
    logic [35:0]          rem_sh;
    logic [35:0]          trial;
    logic                 root_ge;
    logic [48:0]          run_sum;
    logic [47:0]          run_new;
    logic [48:0]          cand;
    logic                 div_ge;
    logic [RW-1:0]        tr_sum;
    logic                 t_carry;
    logic                 last_idx;

    assign u_val     = ONE_Q16 - tq_reg;
    assign jop       = mop_reg - 5'd6;
    assign cop       = mop_reg - 5'd7;
    assign last_idx  = (idx_reg == AW'(DIVN));
    assign task_pop  = (state_reg == S_IDLE) && !task_empty;
    assign out_push  = (state_reg == S_EMIT) && !out_full;

    always_comb
    begin
        case ({jop[3], jop[2:1]})
            3'd0:    coord_val = curve_reg.start_x;
            3'd1:    coord_val = curve_reg.ctrl1_x;
            3'd2:    coord_val = curve_reg.ctrl2_x;
            3'd3:    coord_val = curve_reg.end_x;
            3'd4:    coord_val = curve_reg.start_y;
            3'd5:    coord_val = curve_reg.ctrl1_y;
            3'd6:    coord_val = curve_reg.ctrl2_y;
            default: coord_val = curve_reg.end_y;
        endcase
    end

    assign w_sel = w_reg[jop[2:1]];

    // Operand schedule of the shared multiplier: the Bernstein weights first,
    // then control point times weight halves, then the two squared deltas.
    always_comb
    begin
        case (mop_reg) inside
            5'd0:
            begin
                a_op = {18'b0, u_val};
                b_op = {18'b0, u_val};
            end
            5'd1:
            begin
                a_op = {18'b0, tq_reg};
                b_op = {18'b0, tq_reg};
            end
            5'd2:
            begin
                a_op = {2'b0, u2_reg};
                b_op = {18'b0, u_val};
            end
            5'd3:
            begin
                a_op = {2'b0, u2_reg};
                b_op = {18'b0, tq_reg};
            end
            5'd4:
            begin
                a_op = {2'b0, t2_reg};
                b_op = {18'b0, u_val};
            end
            5'd5:
            begin
                a_op = {2'b0, t2_reg};
                b_op = {18'b0, tq_reg};
            end
            [5'd6:5'd21]:
            begin
                a_op = {{3{coord_val[31]}}, coord_val};
                b_op = jop[0] ? {11'b0, w_sel[23:0]} : {10'b0, w_sel[48:24]};
            end
            5'd22:
            begin
                a_op = {{2{dx_reg[32]}}, dx_reg};
                b_op = {{2{dx_reg[32]}}, dx_reg};
            end
            5'd24:
            begin
                a_op = {{2{dy_reg[32]}}, dy_reg};
                b_op = {{2{dy_reg[32]}}, dy_reg};
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    assign prod_next = a_op * b_op;
    assign term      = cop[0] ? {{12{prod_reg[69]}}, prod_reg}
                              : {prod_reg[57:0], 24'b0};
    assign acc_coord = acc_reg[79:48];
    assign m3        = prod_reg[48:0] + {prod_reg[47:0], 1'b0};

    assign rem_sh  = {rem_reg[33:0], rad_reg[65:64]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign root_ge = (rem_sh >= trial);

    assign run_sum = {1'b0, run_reg} + {16'b0, root_reg};
    assign run_new = run_sum[48] ? LEN_MAX : run_sum[47:0];

    assign cand   = (step_reg == '0) ? drem_reg : {drem_reg[47:0], 1'b0};
    assign div_ge = (cand >= {1'b0, run_reg});

    assign tr_sum  = tr_reg + RW'(STEP_R);
    assign t_carry = (tr_sum >= RW'(DIVN));

    assign out_data.entry_index  = 6'(idx_reg);
    assign out_data.norm_length  = quo_reg;
    assign out_data.param_t      = tq_reg;
    assign out_data.total_length = run_reg;
    assign out_data.last_entry   = last_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            mop_reg   <= '0;
            step_reg  <= '0;
            tq_reg    <= '0;
            tr_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!task_empty)
                    begin
                        idx_reg   <= '0;
                        mop_reg   <= '0;
                        tq_reg    <= '0;
                        tr_reg    <= '0;
                        state_reg <= task_data.flat ? S_READ : S_MUL;
                    end
                end
                S_MUL:
                begin
                    mop_reg <= mop_reg + 5'd1;
                    if (mop_reg == 5'd25)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == ROOT_LAST)
                    begin
                        state_reg <= S_ACCUM;
                    end
                end
                S_ACCUM:
                begin
                    mop_reg <= '0;
                    if (last_idx)
                    begin
                        idx_reg   <= '0;
                        tq_reg    <= '0;
                        tr_reg    <= '0;
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        tr_reg    <= t_carry ? tr_sum - RW'(DIVN) : tr_sum;
                        tq_reg    <= tq_reg + 17'(STEP_Q) + {16'b0, t_carry};
                        state_reg <= S_MUL;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    step_reg <= '0;
                    if ((idx_reg == '0) || last_idx || (run_reg == '0))
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_DIVIDE;
                    end
                end
                S_DIVIDE:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == QUO_LAST)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!out_full)
                    begin
                        if (last_idx)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            tr_reg    <= t_carry ? tr_sum - RW'(DIVN) : tr_sum;
                            tq_reg    <= tq_reg + 17'(STEP_Q) + {16'b0, t_carry};
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        rdata_reg <= mem[idx_reg];
        case (state_reg)
            S_IDLE:
            begin
                curve_reg <= task_data.curve;
                run_reg   <= '0;
                prevx_reg <= task_data.curve.start_x;
                prevy_reg <= task_data.curve.start_y;
            end
            S_MUL:
            begin
                case (mop_reg) inside
                    5'd1: u2_reg   <= prod_reg[32:0];
                    5'd2: t2_reg   <= prod_reg[32:0];
                    5'd3: w_reg[0] <= prod_reg[48:0];
                    5'd4: w_reg[1] <= m3;
                    5'd5: w_reg[2] <= m3;
                    5'd6: w_reg[3] <= prod_reg[48:0];
                    5'd7: acc_reg  <= term;
                    5'd15:
                    begin
                        // The x sum is complete; the y sum starts over.
                        acc_reg <= term;
                        cx_reg  <= acc_coord;
                        dx_reg  <= {acc_coord[31], acc_coord} - {prevx_reg[31], prevx_reg};
                    end
                    [5'd8:5'd22]: acc_reg <= acc_reg + term;
                    5'd23:
                    begin
                        sq_reg <= prod_reg[64:0];
                        cy_reg <= acc_coord;
                        dy_reg <= {acc_coord[31], acc_coord} - {prevy_reg[31], prevy_reg};
                    end
                    5'd25:
                    begin
                        rad_reg  <= {1'b0, sq_reg} + {1'b0, prod_reg[64:0]};
                        rem_reg  <= '0;
                        root_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_ROOT:
            begin
                rad_reg  <= {rad_reg[63:0], 2'b00};
                rem_reg  <= root_ge ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[31:0], root_ge};
            end
            S_ACCUM:
            begin
                run_reg      <= run_new;
                mem[idx_reg] <= run_new;
                prevx_reg    <= cx_reg;
                prevy_reg    <= cy_reg;
            end
            S_LOAD:
            begin
                drem_reg <= {1'b0, rdata_reg};
                if (idx_reg == '0)
                begin
                    quo_reg <= '0;
                end
                else if (last_idx)
                begin
                    quo_reg <= ONE_Q16;
                end
                else
                begin
                    quo_reg <= '0;
                end
            end
            S_DIVIDE:
            begin
                drem_reg <= div_ge ? cand - {1'b0, run_reg} : cand;
                quo_reg  <= {quo_reg[15:0], div_ge};
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/bezier_arc_length_table_core.sv =====
// Top level of the cubic Bezier arc-length table block.
// Depends on bal_pkg, bal_front, bal_fifo and bal_engine.

// A curve of four signed Q16.16 control points goes in through a queue-style
// port (push/full) and comes back as TABLE_ENTRIES table entries, in index
// order, through a queue-style result port (empty/pop). Each entry gives the
// sample parameter, the arc length to that sample as a fraction of the total,
// and the total itself; the last entry is flagged. The front end holds one
// curve and a two-deep queue holds more, so curves can be pushed while a
// table is being produced. Each sample runs on the shared multiplier, then
// the square root, then one accumulate step; each interior entry then goes
// through the 17-step divider when the total is nonzero, while the first
// and last entries are set directly. A curve whose control points all
// coincide skips sampling and division. A stalled consumer holds the engine
// on the waiting entry, and the front end keeps accepting curves until the
// curve queue and its holding register are full.
module bezier_arc_length_table_core #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  bal_pkg::bal_curve_t item,
    output logic                empty,
    input  logic                pop,
    output bal_pkg::bal_entry_t result
);
    import bal_pkg::*;

    logic       task_push;
    bal_task_t  task_in;
    logic       task_full;
    logic       task_pop;
    bal_task_t  task_out;
    logic       task_empty;
    logic       out_push;
    bal_entry_t out_in;
    logic       out_full;

    bal_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .task_push (task_push),
        .task_data (task_in),
        .task_full (task_full)
    );

    // Curves wait here while the engine works on an earlier one.
    bal_fifo #(
        .WIDTH ($bits(bal_task_t)),
        .DEPTH (2)
    ) u_task_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (task_push),
        .wdata (task_in),
        .full  (task_full),
        .pop   (task_pop),
        .rdata (task_out),
        .empty (task_empty)
    );

    bal_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_empty (task_empty),
        .task_data  (task_out),
        .task_pop   (task_pop),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_data   (out_in)
    );

    // Finished entries wait here for the consumer.
    bal_fifo #(
        .WIDTH ($bits(bal_entry_t)),
        .DEPTH (2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_in),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// ===== dv/bal_checker.sv =====
// Checker for the cubic Bezier arc-length table block: watches both queue ports,
// predicts every table entry of each accepted curve and compares it with what comes out.
// Depends on bal_pkg.
module bal_checker #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  bal_pkg::bal_curve_t item,
    input  logic                empty,
    input  logic                pop,
    input  bal_pkg::bal_entry_t result,
    output int                  errors,
    output int                  outstanding,
    output int                  entries_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import bal_pkg::*;

    bal_entry_t table_due[$];

    function automatic logic [16:0] sample_t(int i);
        return 17'((longint'(i) * 65536) / (TABLE_ENTRIES - 1));
    endfunction

    // Exact Bernstein evaluation: the weights sum to 2^48 and the shift floors.
    function automatic logic signed [31:0] curve_coord(logic signed [31:0] p0,
            logic signed [31:0] p1, logic signed [31:0] p2, logic signed [31:0] p3,
            logic [16:0] t);
        longint unsigned tt;
        longint unsigned uu;
        logic signed [95:0] acc;
        tt = t;
        uu = 65536 - tt;
        acc = 96'(p0) * $signed({1'b0, 64'(uu * uu * uu)})
            + 96'(p1) * $signed({1'b0, 64'(3 * uu * uu * tt)})
            + 96'(p2) * $signed({1'b0, 64'(3 * uu * tt * tt)})
            + 96'(p3) * $signed({1'b0, 64'(tt * tt * tt)});
        return 32'(acc >>> 48);
    endfunction

    function automatic logic [47:0] chord(logic signed [33:0] dx, logic signed [33:0] dy);
        logic [33:0] ax;
        logic [33:0] ay;
        logic [71:0] sq;
        logic [71:0] cand;
        logic [47:0] root;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sq = 72'(ax) * 72'(ax) + 72'(ay) * 72'(ay);
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = 72'(root | (48'd1 << b));
            if (cand * cand <= sq)
                root = 48'(cand);
        end
        return root;
    endfunction

    task automatic predict_table(bal_curve_t c);
        logic [47:0] partial [TABLE_ENTRIES];
        logic [47:0] run_len;
        logic [47:0] d;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] px;
        logic signed [31:0] py;
        bal_entry_t e;
        run_len = '0;
        px = c.start_x;
        py = c.start_y;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            cx = curve_coord(c.start_x, c.ctrl1_x, c.ctrl2_x, c.end_x, sample_t(i));
            cy = curve_coord(c.start_y, c.ctrl1_y, c.ctrl2_y, c.end_y, sample_t(i));
            d = chord(34'(cx) - 34'(px), 34'(cy) - 34'(py));
            run_len = (d > LEN_MAX - run_len) ? LEN_MAX : run_len + d;
            partial[i] = run_len;
            px = cx;
            py = cy;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            e.entry_index = 6'(i);
            if (i == 0)
                e.norm_length = '0;
            else if (i == TABLE_ENTRIES - 1)
                e.norm_length = ONE_Q16;
            else if (run_len == 0)
                e.norm_length = '0;
            else
                e.norm_length = 17'((72'(partial[i]) << 16) / 72'(run_len));
            e.param_t = sample_t(i);
            e.total_length = run_len;
            e.last_entry = (i == TABLE_ENTRIES - 1);
            table_due.push_back(e);
        end
    endtask

    assign outstanding = table_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        bal_entry_t want;
        if (!rst_n)
        begin
            errors <= 0;
            entries_seen <= 0;
        end
        else
        begin
            if (push && !full)
                predict_table(item);
            if (pop && !empty)
            begin
                entries_seen <= entries_seen + 1;
                if (table_due.size() == 0)
                begin
                    $display("%0t: unexpected entry, expected none, actual %p", $time, result);
                    errors <= errors + 1;
                end
                else
                begin
                    want = table_due.pop_front();
                    if (result !== want)
                    begin
                        $display("%0t: entry mismatch, expected %p, actual %p",
                                 $time, want, result);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/bezier_arc_length_table_core_tb.sv =====
// Top of the testbench for the cubic Bezier arc-length table block: drives curves and
// pops table entries with random gaps and stalls, and gives the verdict.
// Depends on bal_pkg, bezier_arc_length_table_core and bal_checker.
module bezier_arc_length_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bal_pkg::*;

    localparam int ENTRIES = 32;
    // A quiet stretch far beyond the time one curve takes is a hang.
    localparam int QUIET_LIMIT = 40000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    bal_curve_t item = '0;
    logic       empty;
    logic       pop = 1'b0;
    bal_entry_t result;
    int         errors;
    int         outstanding;
    int         entries_seen;
    int         curves_sent = 0;
    int         quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bezier_arc_length_table_core #(.TABLE_ENTRIES(ENTRIES)) DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result)
    );

    bal_checker #(.TABLE_ENTRIES(ENTRIES)) u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result), .errors(errors),
        .outstanding(outstanding), .entries_seen(entries_seen)
    );

    // The consumer switches among free running, light stalls and heavy stalls,
    // so that stalls land on every phase of the table readout.
    always @(negedge clk)
    begin
        int mode;
        int span;
        if (span <= 0)
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 80);
        end
        span = span - 1;
        case (mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            default: pop <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Watchdog: counts cycles in which neither port accepts anything.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("bezier_arc_length_table_core test failed");
            $finish;
        end
    end

    // Holds push high from the falling edge until the request is taken; push is left
    // high afterwards so that back-to-back requests in a burst need no reassignment.
    task automatic send_curve(bal_curve_t c);
        item <= c;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        curves_sent++;
        @(negedge clk);
    endtask

    task automatic idle_cycles(int n);
        push <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic signed [31:0] coord_rand(int kind);
        case (kind)
            0: return $urandom();                                      // full range
            1: return $signed(32'($urandom_range(0, 32'h3FFFF))) - 32'sh20000;
            default: return 32'($urandom_range(0, 1)) ? 32'sh7FFFFFFF : 32'sh80000000;
        endcase
    endfunction

    function automatic bal_curve_t curve_rand();
        bal_curve_t c;
        int kind;
        kind = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
        c.start_x = coord_rand(kind);
        c.start_y = coord_rand(kind);
        c.ctrl1_x = coord_rand(kind);
        c.ctrl1_y = coord_rand(kind);
        c.ctrl2_x = coord_rand(kind);
        c.ctrl2_y = coord_rand(kind);
        c.end_x = coord_rand(kind);
        c.end_y = coord_rand(kind);
        // Now and then all control points coincide, which makes a zero-length curve.
        if ($urandom_range(0, 15) == 0)
            c = {8{c.start_x}};
        return c;
    endfunction

    initial
    begin
        bal_curve_t c;
        int burst;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed curves: degenerate, extreme and straight ones.
        send_curve('0);                                         // zero-length at origin
        send_curve({8{32'sh7FFFFFFF}});                         // zero-length at maximum
        send_curve({8{32'sh80000000}});                         // zero-length at minimum
        c = '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
              32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
        send_curve(c);                                          // corner to corner, longest
        c = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
              32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000};
        send_curve(c);
        c = '{32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh20000, 32'sh0, 32'sh30000, 32'sh0};
        send_curve(c);                                          // straight along x
        c = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh1, 32'sh1};
        send_curve(c);                                          // tiny, mostly flat steps
        c = '{32'sh5, 32'sh5, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh5, 32'sh5};
        send_curve(c);                                          // closed loop, ends coincide
        c = '{32'shFFFFFFFF, 32'sh0, 32'sh0, 32'shFFFFFFFF, 32'sh1, 32'sh0, 32'sh0, 32'sh1};
        send_curve(c);

        // Let everything drain before random traffic.
        idle_cycles(1);
        while (outstanding != 0) @(negedge clk);

        for (int n = 0; n < 100; )
        begin
            burst = $urandom_range(1, 6);
            for (int b = 0; b < burst && n < 100; b++, n++)
                send_curve(curve_rand());
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 3000));
            if (n >= 50 && n < 50 + burst)
            begin
                idle_cycles(1);
                while (outstanding != 0) @(negedge clk);
            end
        end
        push <= 1'b0;

        while (outstanding != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d curves and checked %0d table entries, including zero-length,",
                 curves_sent, entries_seen);
        $display("extreme-coordinate and random curves under random gaps and stalls.");
        if (errors == 0 && outstanding == 0)
            $display("bezier_arc_length_table_core test passed");
        else
            $display("bezier_arc_length_table_core test failed");
        $finish;
    end
endmodule
